### design/adaptive_random_search_step_top_defines.svh
// assertion macros used by the datapath
`ifndef ADAPTIVE_RANDOM_SEARCH_STEP_TOP_DEFINES_SVH
`define ADAPTIVE_RANDOM_SEARCH_STEP_TOP_DEFINES_SVH

// implication checked every cycle outside reset
`define ARS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ARS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// types, constants and helper functions of the adaptive random search block
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int MaxParamsDef = 16;

  localparam logic [1:0] REQ_DECLARE  = 2'd0;
  localparam logic [1:0] REQ_SUBMIT   = 2'd1;
  localparam logic [1:0] REQ_RETRIEVE = 2'd2;

  localparam logic [1:0] CFG_CROSSFADE = 2'd0;
  localparam logic [1:0] CFG_OVERSHOOT = 2'd1;
  localparam logic [1:0] CFG_SEED      = 2'd2;

  localparam logic [15:0] CrossfadeRst = 16'd6554;
  localparam logic [15:0] OvershootRst = 16'd8192;
  localparam logic [31:0] SeedRst      = 32'd1;
  localparam logic [31:0] LfsrTaps     = 32'hD000_0001;
  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_DECLARE = 4'd1,
    OP_LOAD    = 4'd2,
    OP_MUL1    = 4'd3,
    OP_MUL2    = 4'd4,
    OP_STEPUPD = 4'd5,
    OP_CAND    = 4'd6,
    OP_BEST    = 4'd7,
    OP_EMPTY   = 4'd8,
    OP_FULL    = 4'd9,
    OP_SCORE   = 4'd10
  } ars_op_t;

  typedef struct packed {
    ars_op_t    op;
    logic [5:0] idx;
    logic       last;
    logic       emit;
  } ars_cmd_t;

  typedef struct packed {
    logic       imp;
    logic [6:0] count;
  } ars_stat_t;

  // saturate and optionally round to whole numbers
  function automatic logic signed [31:0] fit_value(input logic signed [33:0] v,
                                                   input logic whole);
    logic        [33:0] mag;
    logic signed [34:0] r;
    logic signed [34:0] hi;
    mag = v[33] ? 34'(-v) : 34'(v);
    mag = (mag + 34'h8000) & ~34'hFFFF;
    r   = whole ? (v[33] ? -$signed({1'b0, mag}) : $signed({1'b0, mag}))
                : 35'(v);
    hi  = whole ? 35'sh7FFF_0000 : 35'sh7FFF_FFFF;
    if (r > hi) r = hi;
    if (r < -35'sh8000_0000) r = -35'sh8000_0000;
    return r[31:0];
  endfunction

endpackage

### design/adaptive_random_search_step_top.sv
// ----------------------------------------------------------------------------
// adaptive_random_search_step_top
// adaptive step random search minimizer, q16.16 values
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy low; results appear one
// per cycle-strobe on out_valid and cannot be stalled. Declare and empty-table
// requests give one result in the cycle after they are taken. A submit scores
// first, on improvement runs load, mul1 and step-update states per parameter,
// then load, mul1, mul2 and write states per parameter for candidates (one
// shared multiplier chain, one table read port); a retrieve runs load and
// write states per parameter. No new transaction is taken until the last result is issued.
module adaptive_random_search_step_top import ars_pkg::*; #(
  parameter int MaxParams = MaxParamsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_start_value,
  input  logic [30:0]        in_start_range,
  input  logic               in_is_integer,
  input  logic signed [31:0] in_score,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic [3:0]         out_param_index,
  output logic signed [31:0] out_param_value,
  output logic               out_improved,
  output logic signed [31:0] out_best_score,
  output logic               out_table_full,
  output logic               out_last
);

  ars_cmd_t  cmd;
  ars_stat_t stat;
  logic      go;

  assign go = start && !busy;

  ars_ctrl #(.MaxParams(MaxParams)) u_ctrl (
    .clk, .rst_n, .start(go), .req_type(in_req_type), .stat, .busy, .cmd
  );

  ars_dp #(.MaxParams(MaxParams)) u_dp (
    .clk, .rst_n, .cmd, .cfg_we, .cfg_index, .cfg_data,
    .start_value(in_start_value), .start_range(in_start_range),
    .is_integer(in_is_integer), .score(in_score), .stat,
    .out_valid, .out_param_index, .out_param_value, .out_improved,
    .out_best_score, .out_table_full, .out_last
  );

endmodule

### design/ars_ctrl.sv
// ----------------------------------------------------------------------------
// ars_ctrl
// sequencer that walks the parameter table and issues datapath commands
// ----------------------------------------------------------------------------
module ars_ctrl import ars_pkg::*; #(
  parameter int MaxParams = MaxParamsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  ars_stat_t  stat,
  output logic       busy,
  output ars_cmd_t   cmd
);

  localparam int IW = $clog2(MaxParams + 1) + 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_UPLD = 8'b0000_0010,
    ST_UM1  = 8'b0000_0100,
    ST_UWR  = 8'b0000_1000,
    ST_CLD  = 8'b0001_0000,
    ST_CM1  = 8'b0010_0000,
    ST_CM2  = 8'b0100_0000,
    ST_CWR  = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        ret_r, ret_nxt;
  logic [IW-1:0] cnt;
  logic        lastp;

  assign cnt   = IW'(stat.count);
  assign lastp = (IW'(idx_r) + IW'(1)) == cnt;
  assign busy  = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ret_nxt   = ret_r;
    cmd       = '{op: OP_NONE, idx: idx_r, last: lastp, emit: 1'b0};
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          case (req_type)
            REQ_DECLARE: begin
              cmd.op   = (cnt >= IW'(MaxParams)) ? OP_FULL : OP_DECLARE;
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
            end
            REQ_SUBMIT: begin
              cmd.op  = OP_SCORE;
              ret_nxt = 1'b0;
              if (cnt == '0) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
              end else begin
                state_nxt = stat.imp ? ST_UPLD : ST_CLD;
              end
            end
            REQ_RETRIEVE: begin
              if (cnt == '0) begin
                cmd.op = OP_EMPTY; cmd.emit = 1'b1; cmd.last = 1'b1;
              end else begin
                ret_nxt = 1'b1; state_nxt = ST_CLD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_UPLD: begin cmd.op = OP_LOAD; state_nxt = ST_UM1; end
      ST_UM1:  begin cmd.op = OP_MUL1; state_nxt = ST_UWR; end
      ST_UWR: begin
        cmd.op = OP_STEPUPD;
        if (lastp) begin idx_nxt = '0; state_nxt = ST_CLD; end
        else begin idx_nxt = idx_r + 6'd1; state_nxt = ST_UPLD; end
      end
      ST_CLD: begin
        cmd.op = OP_LOAD;
        state_nxt = ret_r ? ST_CWR : ST_CM1;
      end
      ST_CM1: begin cmd.op = OP_MUL1; state_nxt = ST_CM2; end
      ST_CM2: begin cmd.op = OP_MUL2; state_nxt = ST_CWR; end
      ST_CWR: begin
        cmd.op   = ret_r ? OP_BEST : OP_CAND;
        cmd.emit = 1'b1;
        if (lastp) state_nxt = ST_IDLE;
        else begin idx_nxt = idx_r + 6'd1; state_nxt = ST_CLD; end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### design/ars_dp.sv
// ----------------------------------------------------------------------------
// ars_dp
// parameter table, lfsr, multipliers and result register
// ----------------------------------------------------------------------------
`include "adaptive_random_search_step_top_defines.svh"
module ars_dp import ars_pkg::*; #(
  parameter int MaxParams = MaxParamsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ars_cmd_t           cmd,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] start_value,
  input  logic [30:0]        start_range,
  input  logic               is_integer,
  input  logic signed [31:0] score,
  output ars_stat_t          stat,
  output logic               out_valid,
  output logic [3:0]         out_param_index,
  output logic signed [31:0] out_param_value,
  output logic               out_improved,
  output logic signed [31:0] out_best_score,
  output logic               out_table_full,
  output logic               out_last
);

  localparam int AW = $clog2(MaxParams) > 0 ? $clog2(MaxParams) : 1;

  logic signed [31:0] best_mem [MaxParams];
  logic signed [31:0] cur_mem  [MaxParams];
  logic [31:0]        step_mem [MaxParams];
  logic               int_mem  [MaxParams];

  logic [15:0] xf_r, os_r;
  logic [31:0] lfsr_r, lfsr_nxt;
  logic [6:0]  count_r;
  logic signed [31:0] bscore_r;
  logic        imp_r;
  logic        score_lt;

  logic signed [31:0] best_q, cur_q;
  logic [31:0] step_q;
  logic        int_q;
  logic [47:0] pa_r;
  logic [47:0] pb_r;
  logic        neg_r;
  logic [15:0] rmag_r;
  logic [AW-1:0] a;
  logic signed [31:0] fit_dec, fit_cand, fit_best;
  logic [32:0] dabs;
  logic [64:0] ssum;
  logic [64:0] mag;
  logic [32:0] mag_c;
  logic signed [33:0] cand_sum;
  logic [31:0] rr;
  logic        lfsr_use;
  logic        cand_mode_r;
  logic        upd_pass_r;

  assign a        = cmd.idx[AW-1:0];
  assign score_lt = score < bscore_r;
  assign stat     = '{imp: score_lt, count: count_r};

  always_comb begin
    lfsr_nxt = {1'b0, lfsr_r[31:1]};
    if (lfsr_r[0]) lfsr_nxt = lfsr_nxt ^ LfsrTaps;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_r     <= CrossfadeRst;
      os_r     <= OvershootRst;
      lfsr_r   <= SeedRst;
      count_r  <= '0;
      bscore_r <= S32Max;
      imp_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CROSSFADE: xf_r <= cfg_data[15:0];
          CFG_OVERSHOOT: os_r <= cfg_data[15:0];
          CFG_SEED:      lfsr_r <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_DECLARE) count_r <= count_r + 7'd1;
      if (cmd.op == OP_SCORE) begin
        imp_r <= score_lt;
        if (score_lt) bscore_r <= score;
      end
      if (cmd.op == OP_LOAD && lfsr_use) lfsr_r <= lfsr_nxt;
    end
  end

  // lfsr advances once per candidate, at load time
  always_ff @(posedge clk) begin
    if (!rst_n) cand_mode_r <= 1'b0;
    else if (cmd.op == OP_SCORE) cand_mode_r <= 1'b1;
    else if (cmd.op == OP_BEST || cmd.op == OP_EMPTY || cmd.op == OP_DECLARE
             || cmd.op == OP_FULL) cand_mode_r <= 1'b0;
    else if (cmd.op == OP_CAND && cmd.last) cand_mode_r <= 1'b0;
    else if (cmd.op == OP_NONE && !cmd.emit) cand_mode_r <= cand_mode_r;
  end
  // during step update the load also happens; only the candidate pass draws
  always_ff @(posedge clk) begin
    if (!rst_n) upd_pass_r <= 1'b0;
    else if (cmd.op == OP_SCORE) upd_pass_r <= score_lt;
    else if (cmd.op == OP_STEPUPD && cmd.last) upd_pass_r <= 1'b0;
  end
  assign lfsr_use = cand_mode_r && !upd_pass_r;

  // table memories, registered reads
  always_ff @(posedge clk) begin
    best_q <= best_mem[a];
    cur_q  <= cur_mem[a];
    step_q <= step_mem[a];
    int_q  <= int_mem[a];
    if (cmd.op == OP_DECLARE) begin
      best_mem[count_r[AW-1:0]] <= fit_dec;
      cur_mem[count_r[AW-1:0]]  <= fit_dec;
      step_mem[count_r[AW-1:0]] <= {1'b0, start_range};
      int_mem[count_r[AW-1:0]]  <= is_integer;
    end
    if (cmd.op == OP_STEPUPD) begin
      step_mem[a] <= (ssum[64:16] > 49'h7FFF_FFFF) ? 32'h7FFF_FFFF : ssum[47:16];
      best_mem[a] <= cur_q;
    end
    if (cmd.op == OP_CAND) cur_mem[a] <= fit_cand;
  end

  assign fit_dec = fit_value(34'(start_value), is_integer);
  assign dabs    = (cur_q >= best_q) ? 33'(cur_q - best_q)
                                     : 33'(best_q - cur_q);
  // r is taken from the state after the shift
  assign rr      = lfsr_nxt;

  // mul1 weights step and |cur-best|, or forms |r|*step; mul2 applies overshoot
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      neg_r  <= rr[31];
      rmag_r <= rr[31] ? 16'(-rr[31:16]) : rr[31:16];
    end
    if (cmd.op == OP_MUL1) begin
      if (upd_pass_r) begin
        pa_r <= 48'(step_q) * 48'(17'h10000 - 17'(xf_r));
        pb_r <= 48'(dabs) * 48'(xf_r);
      end else begin
        pa_r <= 48'(step_q) * 48'(rmag_r);
      end
    end
  end

  assign ssum = 65'(pa_r) + 65'(pb_r) + 65'h8000;

  logic [64:0] mag_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL2) mag_r <= 65'(pa_r) * 65'(os_r);
  end

  assign mag      = (mag_r + (65'd1 << 26)) >> 27;
  // any offset of 2^32 or more saturates the sum either way
  assign mag_c    = (mag[64:32] != '0) ? 33'h1_0000_0000 : mag[32:0];
  assign cand_sum = neg_r ? 34'(best_q) - 34'(mag_c)
                          : 34'(best_q) + 34'(mag_c);
  assign fit_cand = fit_value(cand_sum, int_q);
  assign fit_best = fit_value(34'(best_q), int_q);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_param_index <= 4'(cmd.idx);
      out_param_value <= '0;
      out_improved    <= 1'b0;
      out_table_full  <= 1'b0;
      out_last        <= cmd.last;
      out_best_score  <= bscore_r;
      case (cmd.op)
        OP_DECLARE: begin
          out_param_index <= 4'(count_r);
          out_param_value <= fit_dec;
        end
        OP_FULL: begin
          out_table_full  <= 1'b1;
          out_param_index <= '0;
        end
        OP_SCORE: begin
          out_improved   <= score_lt;
          out_best_score <= score_lt ? score : bscore_r;
          out_param_index <= '0;
        end
        OP_CAND: begin
          out_param_value <= fit_cand;
          out_improved    <= imp_r;
        end
        OP_BEST: out_param_value <= fit_best;
        default: out_param_index <= '0;
      endcase
    end
  end

  `ARS_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= 7'(MaxParams), "count overflow")
  `ARS_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid, "missing result")
  `ARS_ASSERT_NEXT(a_full_flag, clk, rst_n, cmd.op == OP_FULL, out_table_full,
    "table full not flagged")

endmodule

### sim/adaptive_random_search_step_checker.sv
// ----------------------------------------------------------------------------
// adaptive_random_search_step_checker
// watches the request, config and result channels of the search block,
// predicts every result from its own copy of the parameter table and compares
// ----------------------------------------------------------------------------
module adaptive_random_search_step_checker import ars_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_start_value,
  input  logic [30:0]        in_start_range,
  input  logic               in_is_integer,
  input  logic signed [31:0] in_score,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_valid,
  input  logic [3:0]         out_param_index,
  input  logic signed [31:0] out_param_value,
  input  logic               out_improved,
  input  logic signed [31:0] out_best_score,
  input  logic               out_table_full,
  input  logic               out_last,
  output int                 pending,
  output int                 fail_count
);

  typedef struct packed {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               improved;
    logic signed [31:0] best;
    logic               full;
    logic               last;
  } param_result_t;

  localparam int Slots = MaxParamsDef;

  param_result_t      due_results[$];
  logic [15:0]        xfade;
  logic [15:0]        overshoot_q;
  logic [31:0]        lfsr;
  int                 n_params;
  logic signed [31:0] best_score_q;
  logic signed [31:0] best_val[Slots];
  logic signed [31:0] cand_val[Slots];
  logic [31:0]        step_q[Slots];
  logic               whole_q[Slots];

  assign pending = due_results.size();

  // round half away from zero to a whole q16.16 value when asked, then saturate
  function automatic logic signed [31:0] clamp_value(longint v, logic whole);
    longint hi;
    hi = whole ? 64'sh7FFF_0000 : 64'sh7FFF_FFFF;
    if (whole) begin
      if (v >= 0) v = (v + 32'h8000) & ~64'hFFFF;
      else v = -((-v + 32'h8000) & ~64'hFFFF);
    end
    if (v > hi) v = hi;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic int draw_r();
    logic lsb;
    lsb = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) lfsr = lfsr ^ LfsrTaps;
    return int'($signed(lfsr[31:16]));
  endfunction

  function automatic void push_result(int i, logic signed [31:0] v, logic imp,
                                      logic full, logic last);
    param_result_t e;
    e.idx = i[3:0];
    e.value = v;
    e.improved = imp;
    e.best = best_score_q;
    e.full = full;
    e.last = last;
    due_results.push_back(e);
  endfunction

  function automatic void predict_submit(logic signed [31:0] score);
    logic        imp;
    longint      d;
    longint      s;
    int          r;
    longint      q;
    logic [63:0] mag;
    imp = score < best_score_q;
    if (imp) begin
      for (int i = 0; i < n_params; i++) begin
        d = longint'(cand_val[i]) - longint'(best_val[i]);
        if (d < 0) d = -d;
        s = longint'(step_q[i]) * (65536 - longint'(xfade)) + d * longint'(xfade)
            + 32'h8000;
        s = s >>> 16;
        if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
        step_q[i] = s[31:0];
        best_val[i] = cand_val[i];
      end
      best_score_q = score;
    end
    if (n_params == 0) begin
      push_result(0, 0, imp, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < n_params; i++) begin
      r = draw_r();
      mag = 64'(r < 0 ? -r : r) * 64'(step_q[i]) * 64'(overshoot_q);
      q = longint'((mag + (64'd1 << 26)) >> 27);
      if (r < 0) q = -q;
      cand_val[i] = clamp_value(longint'(best_val[i]) + q, whole_q[i]);
      push_result(i, cand_val[i], imp, 1'b0, i + 1 == n_params);
    end
  endfunction

  function automatic void predict_request();
    logic signed [31:0] v;
    case (in_req_type)
      REQ_DECLARE: begin
        if (n_params >= Slots) begin
          push_result(0, 0, 1'b0, 1'b1, 1'b1);
        end else begin
          v = clamp_value(longint'(in_start_value), in_is_integer);
          best_val[n_params] = v;
          cand_val[n_params] = v;
          step_q[n_params] = {1'b0, in_start_range};
          whole_q[n_params] = in_is_integer;
          n_params++;
          push_result(n_params - 1, v, 1'b0, 1'b0, 1'b1);
        end
      end
      REQ_SUBMIT: predict_submit(in_score);
      REQ_RETRIEVE: begin
        if (n_params == 0) push_result(0, 0, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < n_params; i++)
          push_result(i, clamp_value(longint'(best_val[i]), whole_q[i]), 1'b0,
                      1'b0, i + 1 == n_params);
      end
      default: ;  // unknown request, no results
    endcase
  endfunction

  always @(posedge clk) begin
    param_result_t got;
    param_result_t want;
    if (!rst_n) begin
      xfade <= CrossfadeRst;
      overshoot_q <= OvershootRst;
      lfsr = SeedRst;
      n_params = 0;
      best_score_q = S32Max;
      due_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CROSSFADE: xfade <= cfg_data[15:0];
          CFG_OVERSHOOT: overshoot_q <= cfg_data[15:0];
          CFG_SEED: lfsr = (cfg_data == 0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        got = '{out_param_index, out_param_value, out_improved, out_best_score,
                out_table_full, out_last};
        if (due_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: idx %0d value %h", out_param_index,
                     out_param_value);
          fail_count <= fail_count + 1;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch idx/value/imp/best/full/last exp %0d %h %b %h %b %b",
                       want.idx, want.value, want.improved, want.best, want.full,
                       want.last, " got %0d %h %b %h %b %b", got.idx, got.value,
                       got.improved, got.best, got.full, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // a request accepted at this edge cannot already have results out
      if (start && !busy) predict_request();
    end
  end

  initial fail_count = 0;

endmodule

### sim/adaptive_random_search_step_top_tb.sv
// ----------------------------------------------------------------------------
// adaptive_random_search_step_top_tb
// drives declare, submit, retrieve and unknown requests with random gaps through
// several register settings; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module adaptive_random_search_step_top_tb import ars_pkg::*;;

  localparam int DrainCycles = 7 * MaxParamsDef + 20;
  localparam int StallLimit  = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = REQ_DECLARE;
  logic signed [31:0] in_start_value = '0;
  logic [30:0]        in_start_range = '0;
  logic               in_is_integer = 1'b0;
  logic signed [31:0] in_score = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_CROSSFADE;
  logic [31:0]        cfg_data = '0;
  logic               out_valid;
  logic [3:0]         out_param_index;
  logic signed [31:0] out_param_value;
  logic               out_improved;
  logic signed [31:0] out_best_score;
  logic               out_table_full;
  logic               out_last;
  int                 pending;
  int                 fail_count;
  int                 stall_cycles = 0;
  logic               gaps_on = 1'b1;
  logic signed [31:0] score_floor = 32'sh4000_0000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adaptive_random_search_step_top dut (.*);
  adaptive_random_search_step_checker u_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called just after a falling edge; returns just after one
  task automatic send_request(logic [1:0] req, logic signed [31:0] sv,
                              logic [30:0] sr, logic whole,
                              logic signed [31:0] sc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_req_type = req;
    in_start_value = sv;
    in_start_range = sr;
    in_is_integer = whole;
    in_score = sc;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [30:0] rand_range();
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  function automatic logic signed [31:0] rand_score();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return score_floor;
      default: begin
        score_floor = score_floor - 32'($urandom_range(0, 4000));
        return score_floor;
      end
    endcase
  endfunction

  task automatic random_phase(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_request(REQ_DECLARE, $urandom, rand_range(), $urandom_range(0, 1), $urandom);
      else if (pick < 75)
        send_request(REQ_SUBMIT, $urandom, $urandom, $urandom_range(0, 1), rand_score());
      else if (pick < 95)
        send_request(REQ_RETRIEVE, $urandom, $urandom, $urandom_range(0, 1), $urandom);
      else
        send_request(2'd3, $urandom, $urandom, $urandom_range(0, 1), $urandom);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    // empty table, equal score, unknown request
    send_request(REQ_SUBMIT, 0, 0, 1'b0, S32Max);
    send_request(REQ_RETRIEVE, 0, 0, 1'b0, 0);
    send_request(2'd3, '1, '1, 1'b1, '1);
    send_request(REQ_SUBMIT, 0, 0, 1'b0, 32'sh7000_0000);
    // declare extremes, integer rounding and saturation
    send_request(REQ_DECLARE, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 0);
    send_request(REQ_DECLARE, 32'sh7FFF_FFFF, 31'h0, 1'b1, 0);
    send_request(REQ_DECLARE, -32'sh8000, 31'h1_0000, 1'b1, 0);
    send_request(REQ_DECLARE, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b1, 0);
    send_request(REQ_DECLARE, 32'sh0001_8000, 31'h2_0000, 1'b1, 0);
    send_request(REQ_DECLARE, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 0);
    send_request(REQ_SUBMIT, 0, 0, 1'b0, 32'sh7000_0000);
    send_request(REQ_SUBMIT, 0, 0, 1'b0, 32'sh8000_0000);
    send_request(REQ_SUBMIT, 0, 0, 1'b0, 32'sh8000_0000);
    send_request(REQ_RETRIEVE, 0, 0, 1'b0, 0);
    random_phase(80);
    write_reg(CFG_CROSSFADE, 0);
    write_reg(CFG_OVERSHOOT, 16'hFFFF);
    write_reg(CFG_SEED, 0);
    random_phase(80);
    write_reg(CFG_CROSSFADE, 16'hFFFF);
    write_reg(CFG_OVERSHOOT, 0);
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    random_phase(80);
    write_reg(CFG_CROSSFADE, $urandom);
    write_reg(CFG_OVERSHOOT, $urandom);
    write_reg(CFG_SEED, $urandom);
    write_reg(2'd3, $urandom);
    random_phase(80);
    write_reg(CFG_CROSSFADE, 32'hFFFF_0000 | $urandom_range(0, 255));
    write_reg(CFG_OVERSHOOT, 16'h1000);
    random_phase(80);
    gaps_on = 1'b0;
    random_phase(80);
    start = 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < StallLimit) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
